// ----- rtl/heater_mode_and_setpoint_ctrl_unit_macros.svh -----
// assertion macros for the heater mode and setpoint controller checker
// used by: hmsc_checker.sv; expects a clock named clk and a reset named rst
`ifndef HEATER_MODE_AND_SETPOINT_CTRL_UNIT_MACROS_SVH
`define HEATER_MODE_AND_SETPOINT_CTRL_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HMSC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HMSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hmsc_pkg.sv -----
// shared types, codes and constants of the heater mode and setpoint controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hmsc_pkg;

  // widths and fixed constants
  localparam int SP_W             = 9;
  localparam int LIMIT_W          = 16;
  localparam int TIMER_BITS       = 16;
  localparam int SAVE_DELAY_TICKS = 500;
  localparam int SETPOINT_STEP    = 10;
  localparam int CMP_W            = 33;

  // reset values
  localparam logic [SP_W-1:0]    SETPOINT_RST   = 9'd350;
  localparam logic [SP_W-1:0]    MIN_SP_RST     = 9'd150;
  localparam logic [SP_W-1:0]    SAFE_MAX_RST   = 9'd450;
  localparam logic [SP_W-1:0]    BOOST_MAX_RST  = 9'd500;
  localparam logic [LIMIT_W-1:0] BOOST_LIM_RST  = 16'd60000;

  // bus widths
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int ITEM_W  = 12;
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int RESULT_W  = 23;
  localparam int M_TDATA_W = 24;

  // request kinds
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_SLEEP   = 3'd1,
    REQ_WAKE    = 3'd2,
    REQ_LOCK    = 3'd3,
    REQ_UNLOCK  = 3'd4,
    REQ_UP      = 3'd5,
    REQ_DOWN    = 3'd6,
    REQ_RESTORE = 3'd7
  } req_t;

  // sleep and wake reasons
  typedef enum logic [1:0] {
    REASON_MOTION  = 2'd0,
    REASON_STAND   = 2'd1,
    REASON_BUTTONS = 2'd2
  } reason_t;

  // operating mode
  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_ASLEEP = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_t;

  // register indexes
  typedef enum logic [1:0] {
    REG_MIN_SP    = 2'd0,
    REG_SAFE_MAX  = 2'd1,
    REG_BOOST_MAX = 2'd2,
    REG_BOOST_LIM = 2'd3
  } reg_idx_t;

  // request payload carried in tdata, last field lowest
  typedef struct packed {
    logic [SP_W-1:0] restore_value;
    logic            element_present;
    logic [1:0]      event_reason;
  } item_t;

  // result payload, last field lowest
  typedef struct packed {
    logic [SP_W-1:0] save_value;
    logic            save_strobe;
    logic            boost_on;
    mode_t           mode_out;
    logic [SP_W-1:0] setpoint_out;
    logic            heater_on;
  } result_t;

  // configuration register set
  typedef struct packed {
    logic [SP_W-1:0]    min_setpoint;
    logic [SP_W-1:0]    safe_max_setpoint;
    logic [SP_W-1:0]    boost_max_setpoint;
    logic [LIMIT_W-1:0] boost_limit_ticks;
  } cfg_t;

  // mode from the lock and sleep flags, lock wins
  function automatic mode_t mode_of(input logic locked, input logic idle,
                                    input logic stand);
    mode_t m;
    if (locked) m = MODE_LOCKED;
    else if (idle || stand) m = MODE_ASLEEP;
    else m = MODE_ACTIVE;
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hmsc_cfg.sv -----
// configuration register bank on a simple peripheral bus
// depends on: hmsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hmsc_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [hmsc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hmsc_pkg::DATA_W-1:0] pwdata,
  output logic [hmsc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output hmsc_pkg::cfg_t                 cfg
);
  import hmsc_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_setpoint       <= MIN_SP_RST;
      cfg.safe_max_setpoint  <= SAFE_MAX_RST;
      cfg.boost_max_setpoint <= BOOST_MAX_RST;
      cfg.boost_limit_ticks  <= BOOST_LIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_SP:    cfg.min_setpoint       <= pwdata[SP_W-1:0];
        REG_SAFE_MAX:  cfg.safe_max_setpoint  <= pwdata[SP_W-1:0];
        REG_BOOST_MAX: cfg.boost_max_setpoint <= pwdata[SP_W-1:0];
        REG_BOOST_LIM: cfg.boost_limit_ticks  <= pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_MIN_SP:    prdata = DATA_W'(cfg.min_setpoint);
      REG_SAFE_MAX:  prdata = DATA_W'(cfg.safe_max_setpoint);
      REG_BOOST_MAX: prdata = DATA_W'(cfg.boost_max_setpoint);
      REG_BOOST_LIM: prdata = DATA_W'(cfg.boost_limit_ticks);
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/hmsc_core.sv -----
// controller state and its single-pass update for one request
// depends on: hmsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hmsc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire hmsc_pkg::req_t  req_type,
  input  wire hmsc_pkg::item_t item,
  input  wire hmsc_pkg::cfg_t  cfg,
  output hmsc_pkg::result_t    result
);
  import hmsc_pkg::*;

  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

  // state
  logic                  asleep_idle, asleep_stand, locked_flag, heater_enabled;
  logic [SP_W-1:0]       setpoint;
  logic                  boost_flag, change_pending;
  logic [TIMER_BITS-1:0] boost_elapsed, change_elapsed;

  logic                  asleep_idle_next, asleep_stand_next, locked_flag_next;
  logic                  heater_enabled_next;
  logic [SP_W-1:0]       setpoint_next;
  logic                  boost_flag_next, change_pending_next;
  logic [TIMER_BITS-1:0] boost_elapsed_next, change_elapsed_next;

  logic                  strobe;
  logic [SP_W-1:0]       save_val;

  // shared arithmetic
  logic [TIMER_BITS-1:0] boost_inc, change_inc;
  logic [SP_W:0]         sp_sum, floor_lim;
  logic [SP_W-1:0]       sp_up, sp_down;

  assign boost_inc  = (boost_elapsed == CNT_MAX) ? CNT_MAX : boost_elapsed + 1'b1;
  assign change_inc = (change_elapsed == CNT_MAX) ? CNT_MAX : change_elapsed + 1'b1;

  // up is capped at boost maximum, down floored at the minimum
  assign sp_sum    = {1'b0, setpoint} + (SP_W+1)'(SETPOINT_STEP);
  assign sp_up     = (sp_sum > {1'b0, cfg.boost_max_setpoint}) ?
                     cfg.boost_max_setpoint : sp_sum[SP_W-1:0];
  assign floor_lim = {1'b0, cfg.min_setpoint} + (SP_W+1)'(SETPOINT_STEP);
  assign sp_down   = ({1'b0, setpoint} < floor_lim) ?
                     cfg.min_setpoint : setpoint - SP_W'(SETPOINT_STEP);

  // next state for one request
  always_comb begin
    asleep_idle_next    = asleep_idle;
    asleep_stand_next   = asleep_stand;
    locked_flag_next    = locked_flag;
    heater_enabled_next = heater_enabled;
    setpoint_next       = setpoint;
    boost_flag_next     = boost_flag;
    boost_elapsed_next  = boost_elapsed;
    change_pending_next = change_pending;
    change_elapsed_next = change_elapsed;
    strobe              = 1'b0;
    save_val            = '0;

    unique case (req_type)
      REQ_TICK: begin
        boost_elapsed_next  = boost_inc;
        change_elapsed_next = change_inc;
        if (!item.element_present) begin
          heater_enabled_next = 1'b0;
          locked_flag_next    = 1'b1;
        end
        // boost time-out pulls the setpoint back to the safe maximum
        if (boost_flag &&
            CMP_W'(boost_inc) >= CMP_W'(cfg.boost_limit_ticks)) begin
          if (setpoint > cfg.safe_max_setpoint) setpoint_next = cfg.safe_max_setpoint;
          boost_flag_next = 1'b0;
        end
        // stable long enough: offer the setpoint for storage
        if (change_pending && CMP_W'(change_inc) >= CMP_W'(SAVE_DELAY_TICKS)) begin
          strobe              = 1'b1;
          save_val            = (setpoint_next > cfg.safe_max_setpoint) ?
                                cfg.safe_max_setpoint : setpoint_next;
          change_pending_next = 1'b0;
        end
      end
      REQ_SLEEP: begin
        heater_enabled_next = 1'b0;
        case (item.event_reason)
          REASON_MOTION: asleep_idle_next  = 1'b1;
          REASON_STAND:  asleep_stand_next = 1'b1;
          default: ;
        endcase
      end
      REQ_WAKE: begin
        case (item.event_reason) inside
          REASON_MOTION, REASON_BUTTONS: asleep_idle_next = 1'b0;
          REASON_STAND:                  asleep_stand_next = 1'b0;
          default: ;
        endcase
        if (mode_of(locked_flag, asleep_idle_next, asleep_stand_next) == MODE_ACTIVE)
          heater_enabled_next = 1'b1;
      end
      REQ_LOCK: begin
        heater_enabled_next = 1'b0;
        locked_flag_next    = 1'b1;
      end
      REQ_UNLOCK: begin
        locked_flag_next = 1'b0;
        if (mode_of(1'b0, asleep_idle, asleep_stand) == MODE_ACTIVE)
          heater_enabled_next = 1'b1;
      end
      REQ_UP: begin
        setpoint_next = sp_up;
        if (sp_up > cfg.safe_max_setpoint) begin
          boost_flag_next    = 1'b1;
          boost_elapsed_next = '0;
        end
        change_pending_next = 1'b1;
        change_elapsed_next = '0;
      end
      REQ_DOWN: begin
        setpoint_next = sp_down;
        if (sp_down > cfg.safe_max_setpoint) begin
          boost_flag_next    = 1'b1;
          boost_elapsed_next = '0;
        end else begin
          boost_flag_next = 1'b0;
        end
        change_pending_next = 1'b1;
        change_elapsed_next = '0;
      end
      REQ_RESTORE: begin
        setpoint_next = item.restore_value;
      end
    endcase
  end

  // state register, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      asleep_idle    <= 1'b0;
      asleep_stand   <= 1'b0;
      locked_flag    <= 1'b0;
      heater_enabled <= 1'b0;
      setpoint       <= SETPOINT_RST;
      boost_flag     <= 1'b0;
      boost_elapsed  <= '0;
      change_pending <= 1'b0;
      change_elapsed <= '0;
    end else if (fire) begin
      asleep_idle    <= asleep_idle_next;
      asleep_stand   <= asleep_stand_next;
      locked_flag    <= locked_flag_next;
      heater_enabled <= heater_enabled_next;
      setpoint       <= setpoint_next;
      boost_flag     <= boost_flag_next;
      boost_elapsed  <= boost_elapsed_next;
      change_pending <= change_pending_next;
      change_elapsed <= change_elapsed_next;
    end
  end

  // result reflects the state after the update
  always_comb begin
    result.heater_on    = heater_enabled_next;
    result.setpoint_out = setpoint_next;
    result.mode_out     = mode_of(locked_flag_next, asleep_idle_next, asleep_stand_next);
    result.boost_on     = boost_flag_next;
    result.save_strobe  = strobe;
    result.save_value   = save_val;
  end

endmodule

`default_nettype wire

// ----- rtl/heater_mode_and_setpoint_ctrl_unit.sv -----
// heater mode and setpoint controller, top level; depends on hmsc_pkg,
// hmsc_cfg and hmsc_core.
// requests enter on the s_ stream: s_tuser holds the request kind (tick, sleep,
// wake, lock, unlock, up, down, restore), s_tdata the reason, element flag and
// restore value. every request gives exactly one result on the m_ stream:
// heater drive, setpoint, mode, boost flag and the save strobe with its value.
// registers (minimum, safe maximum, boost maximum, boost time) sit on the apb
// port; the user must write them only while no request is in flight.
// the block does not enforce this. a request passes the input register, then
// the output register; the state update is a single pass of logic between
// them. one request per cycle is sustained while m_tready stays high.
// when the receiver stalls the result holds in the output register; the input
// register still takes one more request, then s_tready drops until the
// output drains.
// reset clears both stream stages, the mode flags, the counters and restores
// setpoint 350 and the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module heater_mode_and_setpoint_ctrl_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [1:0] event_reason, [2] element_present, [11:3] restore_value
  input  wire logic [hmsc_pkg::S_TDATA_W-1:0]  s_tdata,
  // [2:0] req_type
  input  wire logic [hmsc_pkg::S_TUSER_W-1:0]  s_tuser,
  // result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] heater_on, [9:1] setpoint_out, [11:10] mode_out, [12] boost_on,
  // [13] save_strobe, [22:14] save_value
  output logic [hmsc_pkg::M_TDATA_W-1:0]       m_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hmsc_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [hmsc_pkg::DATA_W-1:0]     pwdata,
  output logic [hmsc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import hmsc_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  item_t   in_item;
  req_t    in_req;
  logic    advance;
  result_t result;
  result_t out_data;

  hmsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request moves on when the output register is free or being emptied
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= item_t'(s_tdata[ITEM_W-1:0]);
      in_req  <= req_t'(s_tuser);
    end
  end

  hmsc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .req_type (in_req),
    .item     (in_item),
    .cfg      (cfg),
    .result   (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tdata = M_TDATA_W'(out_data);

endmodule

`default_nettype wire

// ----- rtl/hmsc_checker.sv -----
// port-level checks for the heater mode and setpoint controller, with bind
// depends on: hmsc_pkg, heater_mode_and_setpoint_ctrl_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "heater_mode_and_setpoint_ctrl_unit_macros.svh"

module hmsc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [hmsc_pkg::M_TDATA_W-1:0] m_tdata
);
  import hmsc_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata[RESULT_W-1:0]);

  // stalled result holds
  `HMSC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  // nothing left over from before reset
  `HMSC_ASSERT_IMPLY(a_rst_empty, $past(rst), !m_tvalid, "result present right after reset")
  // heater only drives in active mode
  `HMSC_ASSERT_IMPLY(a_heat_active, m_tvalid && r.heater_on, r.mode_out == MODE_ACTIVE, "heater on outside active mode")
  // save value is zero unless strobed
  `HMSC_ASSERT_IMPLY(a_save_zero, m_tvalid && !r.save_strobe, r.save_value == '0, "save value without strobe")
  // the input stalls only while the output holds a stalled result
  `HMSC_ASSERT_IMPLY(a_no_drop, s_tvalid && !s_tready, m_tvalid && !m_tready, "input stalled with output free")

endmodule

bind heater_mode_and_setpoint_ctrl_unit hmsc_checker u_hmsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
